[src/cfd_pkg.sv]
`default_nettype none
package cfd_pkg;

  localparam int DATA_BYTES = 2;
  localparam int FRAME_LEN  = DATA_BYTES + 5;
  localparam int FILL_W     = $clog2(FRAME_LEN + 1);
  localparam int CMD_POS    = 2;
  localparam int PAY_POS    = 3;
  localparam int XOR_POS    = 2 + DATA_BYTES;
  localparam int TAIL1_POS  = 3 + DATA_BYTES;
  localparam int TAIL2_POS  = 4 + DATA_BYTES;

  localparam int ADDR_W     = 4;
  localparam int APB_DW     = 32;

  localparam logic STATUS_FOUND     = 1'b0;
  localparam logic STATUS_NOT_FOUND = 1'b1;

  typedef logic [7:0] cfd_byte_t;

  typedef enum logic [1:0] {
    REG_HEADER_FIRST,
    REG_HEADER_SECOND,
    REG_TAIL_FIRST,
    REG_TAIL_SECOND
  } cfd_reg_t;

  typedef struct packed {
    cfd_byte_t header_first;
    cfd_byte_t header_second;
    cfd_byte_t tail_first;
    cfd_byte_t tail_second;
  } cfd_cfg_t;

  typedef struct packed {
    logic      valid;
    logic      status;
    cfd_byte_t command_code;
    cfd_byte_t payload_byte;
  } cfd_res_t;

endpackage
`default_nettype wire

[src/command_frame_deframer_top.sv]
// Channel  Dir  Payload
// in_      in   tdata=rx_byte, tuser=buffer_start, tlast=buffer_end
// out_     out  tdata={payload_byte, command_code}, tuser=status
// cfg_     in   APB, 4 byte registers at 0x0/0x4/0x8/0xC
//
// One byte per cycle; a result appears on out_ the cycle after its byte.
// Window shift, header/tail match and data XOR are combinational.
// Synchronous active-low reset clears config, fill count and output valid.
// A stalled result holds in the output register; a new byte is taken
// only when that register is empty or drains in the same cycle.
`default_nettype none
module command_frame_deframer_top (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_tvalid,
  output logic                             in_tready,
  input  wire logic [7:0]                  in_tdata,   // [7:0] rx_byte
  input  wire logic                        in_tuser,   // [0] buffer_start
  input  wire logic                        in_tlast,
  output logic                             out_tvalid,
  input  wire logic                        out_tready,
  output logic [15:0]                      out_tdata,  // [7:0] command_code, [15:8] payload_byte
  output logic                             out_tuser,  // [0] status
  input  wire logic                        cfg_psel,
  input  wire logic                        cfg_penable,
  input  wire logic                        cfg_pwrite,
  input  wire logic [cfd_pkg::ADDR_W-1:0]  cfg_paddr,
  input  wire logic [cfd_pkg::APB_DW-1:0]  cfg_pwdata,
  output logic [cfd_pkg::APB_DW-1:0]       cfg_prdata,
  output logic                             cfg_pready
);
  import cfd_pkg::*;

  cfd_cfg_t  cfg_r;
  cfd_reg_t  reg_sel;
  cfd_res_t  res;
  logic      in_acc, cfg_wr;
  logic      out_valid_r, out_status_r;
  cfd_byte_t out_cmd_r, out_pay_r;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign reg_sel    = cfd_reg_t'(cfg_paddr[ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_wr) begin
      case (reg_sel)
        REG_HEADER_FIRST:  cfg_r.header_first  <= cfg_pwdata[7:0];
        REG_HEADER_SECOND: cfg_r.header_second <= cfg_pwdata[7:0];
        REG_TAIL_FIRST:    cfg_r.tail_first    <= cfg_pwdata[7:0];
        REG_TAIL_SECOND:   cfg_r.tail_second   <= cfg_pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_HEADER_FIRST:  cfg_prdata = {{(APB_DW-8){1'b0}}, cfg_r.header_first};
      REG_HEADER_SECOND: cfg_prdata = {{(APB_DW-8){1'b0}}, cfg_r.header_second};
      REG_TAIL_FIRST:    cfg_prdata = {{(APB_DW-8){1'b0}}, cfg_r.tail_first};
      REG_TAIL_SECOND:   cfg_prdata = {{(APB_DW-8){1'b0}}, cfg_r.tail_second};
      default:           cfg_prdata = '0;
    endcase
  end

  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;

  cfd_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_acc       (in_acc),
    .rx_byte      (in_tdata),
    .buffer_start (in_tuser),
    .buffer_end   (in_tlast),
    .cfg          (cfg_r),
    .res          (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= res.valid;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && res.valid) begin
      out_status_r <= res.status;
      out_cmd_r    <= res.command_code;
      out_pay_r    <= res.payload_byte;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {out_pay_r, out_cmd_r};

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |-> !in_acc)
    else $error("result overwritten while stalled");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && res.valid) |=> out_valid_r)
    else $error("result dropped");

  a_cfg_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !cfg_wr |=> $stable(cfg_r))
    else $error("config changed without write");

endmodule
`default_nettype wire

[src/cfd_core.sv]
`default_nettype none
module cfd_core (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_acc,
  input  wire cfd_pkg::cfd_byte_t  rx_byte,
  input  wire logic                buffer_start,
  input  wire logic                buffer_end,
  input  wire cfd_pkg::cfd_cfg_t   cfg,
  output cfd_pkg::cfd_res_t        res
);
  import cfd_pkg::*;

  cfd_byte_t         win_r   [FRAME_LEN];
  cfd_byte_t         win_nxt [FRAME_LEN];
  logic [FILL_W-1:0] fill_r, fill_base, fill_nxt;
  logic              seen_r, seen_base, seen_nxt;
  cfd_byte_t         x;
  logic              is_frame, found;

  always_comb begin
    fill_base = buffer_start ? '0 : fill_r;
    seen_base = buffer_start ? 1'b0 : seen_r;
    for (int i = 0; i < FRAME_LEN - 1; i++) begin
      win_nxt[i] = win_r[i + 1];
    end
    win_nxt[FRAME_LEN - 1] = rx_byte;
    x = '0;
    for (int i = 0; i < DATA_BYTES; i++) begin
      x = x ^ win_nxt[CMD_POS + i];
    end
    // window is full after this byte when it held FRAME_LEN-1 or more before
    is_frame = (fill_base >= FILL_W'(FRAME_LEN - 1)) &&
               (win_nxt[0] == cfg.header_first) &&
               (win_nxt[1] == cfg.header_second) &&
               (win_nxt[XOR_POS] == x) &&
               (win_nxt[TAIL1_POS] == cfg.tail_first) &&
               (win_nxt[TAIL2_POS] == cfg.tail_second);
    found = !seen_base && is_frame;

    res.valid        = found || (buffer_end && !seen_base);
    res.status       = found ? STATUS_FOUND : STATUS_NOT_FOUND;
    res.command_code = found ? win_nxt[CMD_POS] : '0;
    res.payload_byte = found ? win_nxt[PAY_POS] : '0;

    fill_nxt = (fill_base == FILL_W'(FRAME_LEN)) ? fill_base : fill_base + 1'b1;
    seen_nxt = seen_base | found;
    if (buffer_end) begin
      fill_nxt = '0;
      seen_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      seen_r <= 1'b0;
    end else if (in_acc) begin
      fill_r <= fill_nxt;
      seen_r <= seen_nxt;
    end
  end

  // stale window bytes are masked by fill_r
  always_ff @(posedge clk) begin
    if (in_acc) begin
      win_r <= win_nxt;
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_W'(FRAME_LEN))
    else $error("fill count beyond frame length");

  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && buffer_end) |=> (fill_r == '0 && !seen_r))
    else $error("buffer end did not clear state");

  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    (seen_r && !buffer_start) |-> !res.valid)
    else $error("second result in one buffer");

  a_found_marks: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && res.valid && res.status == STATUS_FOUND && !buffer_end) |=> seen_r)
    else $error("found frame not recorded");

  a_seen_full: assert property (@(posedge clk) disable iff (!rst_n)
    seen_r |-> fill_r == FILL_W'(FRAME_LEN))
    else $error("frame marked with partial window");

endmodule
`default_nettype wire

[test/cfd_checker.sv]
module cfd_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  input  logic                       in_tready,
  input  logic [7:0]                 in_tdata,   // [7:0] rx_byte
  input  logic                       in_tuser,   // [0] buffer_start
  input  logic                       in_tlast,
  input  logic                       out_tvalid,
  input  logic                       out_tready,
  input  logic [15:0]                out_tdata,  // [7:0] command_code, [15:8] payload_byte
  input  logic                       out_tuser,  // [0] status
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [cfd_pkg::ADDR_W-1:0] cfg_paddr,
  input  logic [cfd_pkg::APB_DW-1:0] cfg_pwdata,
  input  logic                       cfg_pready,
  output int                         fail_count = 0,
  output int                         pending = 0
);
  import cfd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic      status;
    cfd_byte_t command_code;
    cfd_byte_t payload_byte;
  } frame_result_t;

  frame_result_t frame_result_q[$];
  cfd_byte_t     win [FRAME_LEN];
  int unsigned   fill;
  logic          seen;
  cfd_cfg_t      regs;

  function automatic void clear_window();
    foreach (win[i]) win[i] = '0;
    fill = 0;
    seen = 1'b0;
  endfunction

  task automatic deframe_byte(input cfd_byte_t b, input logic is_start, input logic is_end);
    cfd_byte_t     parity;
    logic          hit;
    frame_result_t r;
    if (is_start) clear_window();
    for (int i = 0; i < FRAME_LEN - 1; i++) win[i] = win[i+1];
    win[FRAME_LEN-1] = b;
    if (fill < FRAME_LEN) fill++;
    parity = '0;
    for (int i = 0; i < DATA_BYTES; i++) parity ^= win[CMD_POS+i];
    hit = (fill == FRAME_LEN) && (win[0] == regs.header_first) &&
          (win[1] == regs.header_second) && (parity == win[XOR_POS]) &&
          (win[TAIL1_POS] == regs.tail_first) && (win[TAIL2_POS] == regs.tail_second);
    if (!seen && hit) begin
      seen = 1'b1;
      r.status       = STATUS_FOUND;
      r.command_code = win[CMD_POS];
      r.payload_byte = win[PAY_POS];
      frame_result_q.push_back(r);
    end else if (is_end && !seen) begin
      r.status       = STATUS_NOT_FOUND;
      r.command_code = '0;
      r.payload_byte = '0;
      frame_result_q.push_back(r);
    end
    if (is_end) clear_window();
  endtask

  always @(posedge clk) begin
    frame_result_t exp_r;
    if (!rst_n) begin
      clear_window();
      regs = '0;
      frame_result_q.delete();
    end else begin
      // drain first: a result always belongs to an earlier byte
      if (out_tvalid && out_tready) begin
        if (frame_result_q.size() == 0) begin
          $error("unexpected result beat: status %0d data 0x%04h", out_tuser, out_tdata);
          fail_count++;
        end else begin
          exp_r = frame_result_q.pop_front();
          if (out_tuser !== exp_r.status) begin
            $error("status: expected %0d, got %0d", exp_r.status, out_tuser);
            fail_count++;
          end
          if (out_tdata[7:0] !== exp_r.command_code) begin
            $error("command_code: expected 0x%02h, got 0x%02h",
                   exp_r.command_code, out_tdata[7:0]);
            fail_count++;
          end
          if (out_tdata[15:8] !== exp_r.payload_byte) begin
            $error("payload_byte: expected 0x%02h, got 0x%02h",
                   exp_r.payload_byte, out_tdata[15:8]);
            fail_count++;
          end
        end
      end
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfd_reg_t'(cfg_paddr[3:2]))
          REG_HEADER_FIRST:  regs.header_first  = cfg_pwdata[7:0];
          REG_HEADER_SECOND: regs.header_second = cfg_pwdata[7:0];
          REG_TAIL_FIRST:    regs.tail_first    = cfg_pwdata[7:0];
          REG_TAIL_SECOND:   regs.tail_second   = cfg_pwdata[7:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) deframe_byte(in_tdata, in_tuser, in_tlast);
    end
    pending = frame_result_q.size();
  end

endmodule

[test/tb_command_frame_deframer_top.sv]
module tb_command_frame_deframer_top;
  import cfd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  logic [7:0]        in_tdata;   // [7:0] rx_byte
  logic              in_tuser;   // [0] buffer_start
  logic              in_tlast;
  logic              out_tvalid;
  logic              out_tready;
  logic [15:0]       out_tdata;  // [7:0] command_code, [15:8] payload_byte
  logic              out_tuser;  // [0] status
  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [ADDR_W-1:0] cfg_paddr;
  logic [APB_DW-1:0] cfg_pwdata;
  logic [APB_DW-1:0] cfg_prdata;
  logic              cfg_pready;
  int                fail_count;
  int                pending;

  int                send_idle_pct = 0;
  int                stall_pct = 0;
  int                hold_len = 0;
  cfd_cfg_t          cur_cfg = '0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  command_frame_deframer_top u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  cfd_checker u_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_pready  (cfg_pready),
    .fail_count  (fail_count),
    .pending     (pending)
  );

  // result side: random stalls plus an occasional long hold-off
  initial begin
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_len > 0) begin
        out_tready <= 1'b0;
        for (int k = 0; k < hold_len; k++) @(posedge clk);
        hold_len = 0;
      end
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  initial begin
    #2_000_000;
    $display("FAIL command_frame_deframer_top");
    $finish;
  end

  task automatic send_byte(input cfd_byte_t b, input logic is_start, input logic is_end);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= is_start;
    in_tlast  <= is_end;
    do @(posedge clk); while (!in_tready);
  endtask

  // first beat may carry buffer_start, last beat carries buffer_end; noisy buffers also set either flag on random beats
  task automatic send_buffer(input cfd_byte_t bytes[$], input logic with_start,
                             input logic noisy, inout int sent);
    logic s;
    logic e;
    foreach (bytes[i]) begin
      s = (i == 0) && with_start;
      e = (i == bytes.size() - 1);
      if (noisy && $urandom_range(99) < 8) s = 1'b1;
      if (noisy && $urandom_range(99) < 8) e = 1'b1;
      send_byte(bytes[i], s, e);
      sent++;
    end
  endtask

  task automatic add_frame(inout cfd_byte_t bytes[$], input cfd_byte_t cmd,
                           input cfd_byte_t pay, input logic corrupt);
    cfd_byte_t fr[$];
    cfd_byte_t parity;
    int        pos;
    fr.push_back(cur_cfg.header_first);
    fr.push_back(cur_cfg.header_second);
    fr.push_back(cmd);
    fr.push_back(pay);
    for (int i = 2; i < DATA_BYTES; i++) fr.push_back(cfd_byte_t'($urandom_range(255)));
    parity = '0;
    for (int i = 0; i < DATA_BYTES; i++) parity ^= fr[CMD_POS+i];
    fr.push_back(parity);
    fr.push_back(cur_cfg.tail_first);
    fr.push_back(cur_cfg.tail_second);
    if (corrupt) begin
      pos = $urandom_range(FRAME_LEN - 1);
      fr[pos] ^= cfd_byte_t'($urandom_range(1, 255));
    end
    foreach (fr[i]) bytes.push_back(fr[i]);
  endtask

  task automatic add_noise(inout cfd_byte_t bytes[$], input int n);
    repeat (n) begin
      case ($urandom_range(3))
        0: bytes.push_back(cur_cfg.header_first);
        1: bytes.push_back(cur_cfg.header_second);
        default: bytes.push_back(cfd_byte_t'($urandom_range(255)));
      endcase
    end
  endtask

  task automatic random_buffer(inout int sent);
    cfd_byte_t bytes[$];
    int        kind;
    kind = $urandom_range(99);
    add_noise(bytes, $urandom_range(3));
    if (kind < 75) begin
      add_frame(bytes, cfd_byte_t'($urandom_range(255)), cfd_byte_t'($urandom_range(255)),
                $urandom_range(9) == 0);
    end else begin
      add_noise(bytes, $urandom_range(10));
    end
    if (kind < 20) begin
      add_noise(bytes, $urandom_range(2));
      add_frame(bytes, cfd_byte_t'($urandom_range(255)), cfd_byte_t'($urandom_range(255)),
                $urandom_range(4) == 0);
    end
    add_noise(bytes, $urandom_range(2));
    if (bytes.size() == 0) bytes.push_back(cfd_byte_t'($urandom_range(255)));
    send_buffer(bytes, $urandom_range(3) != 0, kind >= 92, sent);
  endtask

  task automatic write_reg(input cfd_reg_t r, input cfd_byte_t v);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {r, 2'b00};
    cfg_pwdata  <= {24'b0, v};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_regs(input cfd_cfg_t c);
    cur_cfg = c;
    write_reg(REG_HEADER_FIRST, c.header_first);
    write_reg(REG_HEADER_SECOND, c.header_second);
    write_reg(REG_TAIL_FIRST, c.tail_first);
    write_reg(REG_TAIL_SECOND, c.tail_second);
  endtask

  // sender idle until every result is back, then let the pipe settle
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    cfd_byte_t bytes[$];
    cfd_cfg_t  c;
    int        sent;
    logic      held;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = 1'b0;
    in_tlast    = 1'b0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed, reset register values
    sent = 0;
    bytes = '{8'hFF};
    send_buffer(bytes, 1'b1, 1'b0, sent);
    bytes = '{8'h00, 8'hFF, 8'h00};
    send_buffer(bytes, 1'b1, 1'b0, sent);
    bytes.delete();
    add_frame(bytes, 8'hFF, 8'h00, 1'b0);
    send_buffer(bytes, 1'b1, 1'b0, sent);
    bytes.delete();
    add_frame(bytes, 8'h5A, 8'hA5, 1'b0);
    add_frame(bytes, 8'h01, 8'h80, 1'b0);
    bytes.push_back(8'h00);
    send_buffer(bytes, 1'b0, 1'b0, sent);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 72; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 72; end
        default: begin send_idle_pct = 6; stall_pct = 6; end
      endcase
      case (ph)
        0: c = '{8'h00, 8'h00, 8'h00, 8'h00};
        1: c = '{8'hFF, 8'hFF, 8'hFF, 8'hFF};
        4: c = '{8'hFF, 8'h00, 8'h00, 8'hFF};
        default: c = '{cfd_byte_t'($urandom_range(255)), cfd_byte_t'($urandom_range(255)),
                       cfd_byte_t'($urandom_range(255)), cfd_byte_t'($urandom_range(255))};
      endcase
      set_regs(c);
      sent = 0;
      held = 1'b0;
      while (sent < 100) begin
        if (ph == 0 && !held && sent >= 30) begin
          hold_len = 120;
          held = 1'b1;
        end
        random_buffer(sent);
      end
      drain();
    end

    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS command_frame_deframer_top");
    end else begin
      $display("FAIL command_frame_deframer_top");
    end
    $finish;
  end

endmodule
